// File: rtl/tcpu_eu_pkg.sv
`default_nettype none

package tcpu_eu_pkg;

    localparam int DEF_NUM_REGS   = 16;
    localparam int DEF_MEM_WORDS  = 256;
    localparam int DEF_PROG_DEPTH = 4096;

    localparam int OPC_W    = 4;
    localparam int IDX_W    = 4;
    localparam int DATA_W   = 32;
    localparam int PC_OUT_W = 12;
    localparam int PLEN_W   = 13;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 56;

    typedef enum logic [OPC_W-1:0] {
        OP_NOP   = 4'd0,
        OP_MOV   = 4'd1,
        OP_ADD   = 4'd2,
        OP_ADDI  = 4'd3,
        OP_SUB   = 4'd4,
        OP_AND   = 4'd5,
        OP_OR    = 4'd6,
        OP_CMP   = 4'd7,
        OP_LOAD  = 4'd8,
        OP_STORE = 4'd9,
        OP_JMP   = 4'd10,
        OP_JZ    = 4'd11,
        OP_JNZ   = 4'd12,
        OP_HALT  = 4'd13
    } opcode_t;

endpackage

`default_nettype wire

// File: rtl/toy_cpu_execute_unit_top.sv
// Execute stage of a small register machine: one instruction per request.
// The input stream (s_*) carries one decoded instruction per request; the
// output stream (m_*) returns one result per instruction: next PC, flags and
// the register write that took place. cfg_* writes program_length and is
// always ready; write it only while no instruction is in flight.
// Register file and data memory sit in synchronous RAMs with a registered
// read. An instruction passes through the address stage, where the memory
// address is reduced modulo the memory size, then the execute stage reading
// the RAMs, and then waits in the output register. Throughput is one
// instruction per cycle while the receiver takes results, with the last
// register and memory write forwarded to the following instruction.
// After reset a clearing pass zeroes both memories, one entry per cycle, over
// the larger of NUM_REGS and MEM_WORDS entries (256 by default); s_tready is
// low during it. When the receiver stalls, the output register holds its
// result and the two stages behind it fill, after which s_tready drops.
`default_nettype none

module toy_cpu_execute_unit_top #(
    parameter int NUM_REGS   = tcpu_eu_pkg::DEF_NUM_REGS,
    parameter int MEM_WORDS  = tcpu_eu_pkg::DEF_MEM_WORDS,
    parameter int PROG_DEPTH = tcpu_eu_pkg::DEF_PROG_DEPTH
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [tcpu_eu_pkg::PLEN_W-1:0]    cfg_data,

    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // opcode[3:0], dest_reg[7:4], source_a[11:8], source_b[15:12],
    // imm_value[47:16].
    input  wire logic [tcpu_eu_pkg::S_TDATA_W-1:0] s_tdata,

    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // next_pc[11:0], is_halted[12], transfer_taken[13], reg_written[14],
    // written_index[18:15], written_value[50:19], zero_out[51], zeros above.
    output logic      [tcpu_eu_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int IW  = tcpu_eu_pkg::IDX_W;
    localparam int DW  = tcpu_eu_pkg::DATA_W;
    localparam int RW  = $clog2(NUM_REGS);
    localparam int AW  = $clog2(MEM_WORDS);
    localparam int PW  = $clog2(PROG_DEPTH);
    localparam int CLR_DEPTH = (NUM_REGS > MEM_WORDS) ? NUM_REGS : MEM_WORDS;
    localparam int CW  = $clog2(CLR_DEPTH);
    localparam longint unsigned RECIP_L = (64'd1 << 32) / 64'(MEM_WORDS);
    localparam logic [31:0] RECIP = 32'(RECIP_L);

    function automatic logic [IW-1:0] reduce_idx(input logic [IW-1:0] v);
        logic [IW:0] r;
        r = {1'b0, v};
        for (int i = 0; i < 8; i++) begin
            if (r >= (IW+1)'(NUM_REGS)) begin
                r = r - (IW+1)'(NUM_REGS);
            end
        end
        return r[IW-1:0];
    endfunction

    // Clearing pass.
    logic          clr_active_reg;
    logic [CW-1:0] clr_cnt_reg;

    // Address stage.
    logic          s1_valid_reg;
    logic [3:0]    s1_op_reg;
    logic [IW-1:0] s1_dst_reg;
    logic [IW-1:0] s1_sa_reg;
    logic [IW-1:0] s1_sb_reg;
    logic [DW-1:0] s1_imm_reg;
    logic [63:0]   s1_prod_reg;

    // Execute stage.
    logic          s2_valid_reg;
    logic [3:0]    s2_op_reg;
    logic [IW-1:0] s2_dst_reg;
    logic [DW-1:0] s2_imm_reg;
    logic [AW-1:0] s2_addr_reg;
    logic          s2_hit_a_reg;
    logic          s2_hit_b_reg;
    logic          s2_hit_m_reg;

    logic [DW-1:0] fwd_reg_val_reg;
    logic [DW-1:0] fwd_mem_val_reg;

    // Architectural state.
    logic [PW-1:0]                   pc_reg;
    logic                            halt_reg;
    logic                            zero_reg;
    logic [tcpu_eu_pkg::PLEN_W-1:0]  plen_reg;

    logic                              m_valid_reg;
    logic [tcpu_eu_pkg::M_TDATA_W-1:0] m_data_reg;

    logic accept;
    logic adv2;
    logic ex_fire;

    logic [IW-1:0] s1_sa_red;
    logic [IW-1:0] s1_sb_red;
    logic [IW-1:0] s1_dst_red;
    logic [31:0]   s1_q;
    logic [32:0]   s1_qm;
    logic [32:0]   s1_rem_raw;
    logic [32:0]   s1_rem;
    logic [AW-1:0] s1_addr;

    logic [DW-1:0] rfa_rd;
    logic [DW-1:0] rfb_rd;
    logic [DW-1:0] dm_rd;
    logic [DW-1:0] op_a;
    logic [DW-1:0] op_b;
    logic [DW-1:0] op_m;

    logic [PW-1:0] pc_next;
    logic          halt_next;
    logic          zero_next;
    logic          taken;
    logic          wrote;
    logic          store;
    logic [DW-1:0] wval;

    logic          rf_we;
    logic [RW-1:0] rf_waddr;
    logic [DW-1:0] rf_wdata;
    logic          dm_we;
    logic [AW-1:0] dm_waddr;
    logic [DW-1:0] dm_wdata;

    assign ex_fire   = s2_valid_reg && (!m_valid_reg || m_tready);
    assign adv2      = s1_valid_reg && (!s2_valid_reg || ex_fire);
    assign s_tready  = !clr_active_reg && (!s1_valid_reg || adv2);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign s1_sa_red  = reduce_idx(s1_sa_reg);
    assign s1_sb_red  = reduce_idx(s1_sb_reg);
    assign s1_dst_red = reduce_idx(s1_dst_reg);

    assign s1_q       = s1_prod_reg[63:32];
    assign s1_qm      = 33'({1'b0, s1_q} * 33'(MEM_WORDS));
    assign s1_rem_raw = {1'b0, s1_imm_reg} - s1_qm;
    assign s1_rem     = (s1_rem_raw >= 33'(MEM_WORDS)) ? s1_rem_raw - 33'(MEM_WORDS)
                                                       : s1_rem_raw;
    assign s1_addr    = AW'(s1_rem);

    assign op_a = s2_hit_a_reg ? fwd_reg_val_reg : rfa_rd;
    assign op_b = s2_hit_b_reg ? fwd_reg_val_reg : rfb_rd;
    assign op_m = s2_hit_m_reg ? fwd_mem_val_reg : dm_rd;

    always_comb begin
        pc_next   = pc_reg;
        halt_next = halt_reg;
        zero_next = zero_reg;
        taken     = 1'b0;
        wrote     = 1'b0;
        store     = 1'b0;
        wval      = '0;
        if (!halt_reg && (33'(pc_reg) >= 33'(plen_reg))) begin
            halt_next = 1'b1;
        end
        if (!halt_next) begin
            if ((33'(pc_reg) + 33'd1) >= 33'(PROG_DEPTH)) begin
                pc_next   = PW'(PROG_DEPTH - 1);
                halt_next = 1'b1;
            end else begin
                pc_next = pc_reg + PW'(1);
            end
            case (tcpu_eu_pkg::opcode_t'(s2_op_reg))
                tcpu_eu_pkg::OP_MOV: begin
                    wrote = 1'b1;
                    wval  = s2_imm_reg;
                end
                tcpu_eu_pkg::OP_ADD: begin
                    wrote = 1'b1;
                    wval  = op_a + op_b;
                end
                tcpu_eu_pkg::OP_ADDI: begin
                    wrote = 1'b1;
                    wval  = op_a + s2_imm_reg;
                end
                tcpu_eu_pkg::OP_SUB: begin
                    wrote = 1'b1;
                    wval  = op_a - op_b;
                end
                tcpu_eu_pkg::OP_AND: begin
                    wrote = 1'b1;
                    wval  = op_a & op_b;
                end
                tcpu_eu_pkg::OP_OR: begin
                    wrote = 1'b1;
                    wval  = op_a | op_b;
                end
                tcpu_eu_pkg::OP_CMP: begin
                    zero_next = (op_a == op_b);
                end
                tcpu_eu_pkg::OP_LOAD: begin
                    wrote = 1'b1;
                    wval  = op_m;
                end
                tcpu_eu_pkg::OP_STORE: begin
                    store = 1'b1;
                end
                tcpu_eu_pkg::OP_JMP, tcpu_eu_pkg::OP_JZ, tcpu_eu_pkg::OP_JNZ: begin
                    if ((s2_op_reg == tcpu_eu_pkg::OP_JMP) ||
                        ((s2_op_reg == tcpu_eu_pkg::OP_JZ) && zero_reg) ||
                        ((s2_op_reg == tcpu_eu_pkg::OP_JNZ) && !zero_reg)) begin
                        taken = 1'b1;
                        if ({1'b0, s2_imm_reg} >= 33'(PROG_DEPTH)) begin
                            pc_next   = PW'(PROG_DEPTH - 1);
                            halt_next = 1'b1;
                        end else begin
                            pc_next = PW'(s2_imm_reg);
                        end
                    end
                end
                tcpu_eu_pkg::OP_HALT: begin
                    halt_next = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (clr_active_reg) begin
            rf_we    = (33'(clr_cnt_reg) < 33'(NUM_REGS));
            rf_waddr = RW'(clr_cnt_reg);
            rf_wdata = '0;
            dm_we    = (33'(clr_cnt_reg) < 33'(MEM_WORDS));
            dm_waddr = AW'(clr_cnt_reg);
            dm_wdata = '0;
        end else begin
            rf_we    = ex_fire && wrote;
            rf_waddr = RW'(s2_dst_reg);
            rf_wdata = wval;
            dm_we    = ex_fire && store;
            dm_waddr = s2_addr_reg;
            dm_wdata = op_a;
        end
    end

    tcpu_eu_ram #(
        .WIDTH (DW),
        .DEPTH (NUM_REGS)
    ) u_rf_a (
        .aclk    (aclk),
        .wr_en   (rf_we),
        .wr_addr (rf_waddr),
        .wr_data (rf_wdata),
        .rd_en   (adv2),
        .rd_addr (RW'(s1_sa_red)),
        .rd_data (rfa_rd)
    );

    tcpu_eu_ram #(
        .WIDTH (DW),
        .DEPTH (NUM_REGS)
    ) u_rf_b (
        .aclk    (aclk),
        .wr_en   (rf_we),
        .wr_addr (rf_waddr),
        .wr_data (rf_wdata),
        .rd_en   (adv2),
        .rd_addr (RW'(s1_sb_red)),
        .rd_data (rfb_rd)
    );

    tcpu_eu_ram #(
        .WIDTH (DW),
        .DEPTH (MEM_WORDS)
    ) u_dmem (
        .aclk    (aclk),
        .wr_en   (dm_we),
        .wr_addr (dm_waddr),
        .wr_data (dm_wdata),
        .rd_en   (adv2),
        .rd_addr (s1_addr),
        .rd_data (dm_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            pc_reg         <= '0;
            halt_reg       <= 1'b0;
            zero_reg       <= 1'b0;
            plen_reg       <= '0;
        end else begin
            if (clr_active_reg) begin
                if (clr_cnt_reg == CW'(CLR_DEPTH - 1)) begin
                    clr_active_reg <= 1'b0;
                end
                clr_cnt_reg <= clr_cnt_reg + CW'(1);
            end

            if (cfg_valid) begin
                plen_reg <= cfg_data;
            end

            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (adv2) begin
                s1_valid_reg <= 1'b0;
            end

            if (adv2) begin
                s2_valid_reg <= 1'b1;
            end else if (ex_fire) begin
                s2_valid_reg <= 1'b0;
            end

            if (ex_fire) begin
                m_valid_reg <= 1'b1;
                pc_reg      <= pc_next;
                halt_reg    <= halt_next;
                zero_reg    <= zero_next;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_op_reg   <= s_tdata[3:0];
            s1_dst_reg  <= s_tdata[7:4];
            s1_sa_reg   <= s_tdata[11:8];
            s1_sb_reg   <= s_tdata[15:12];
            s1_imm_reg  <= s_tdata[47:16];
            s1_prod_reg <= 64'(s_tdata[47:16]) * 64'(RECIP);
        end

        if (adv2) begin
            s2_op_reg    <= s1_op_reg;
            s2_dst_reg   <= s1_dst_red;
            s2_imm_reg   <= s1_imm_reg;
            s2_addr_reg  <= s1_addr;
            s2_hit_a_reg <= ex_fire && wrote && (s2_dst_reg == s1_sa_red);
            s2_hit_b_reg <= ex_fire && wrote && (s2_dst_reg == s1_sb_red);
            s2_hit_m_reg <= ex_fire && store && (s2_addr_reg == s1_addr);
        end

        if (ex_fire) begin
            fwd_reg_val_reg <= wval;
            fwd_mem_val_reg <= op_a;
            m_data_reg      <= {4'b0000, zero_next, wval, wrote ? s2_dst_reg : IW'(0),
                                wrote, taken, halt_next,
                                tcpu_eu_pkg::PC_OUT_W'(pc_next)};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

// File: rtl/tcpu_eu_ram.sv
`default_nettype none

module tcpu_eu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import tcpu_eu_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 200;
    localparam int TOP_PC      = DEF_PROG_DEPTH - 1;
    localparam logic [OPC_W-1:0] OP_SPARE_LO = 4'd14;
    localparam logic [OPC_W-1:0] OP_SPARE_HI = 4'd15;

    typedef struct packed {
        logic [DATA_W-1:0] imm;
        logic [IDX_W-1:0]  src_b;
        logic [IDX_W-1:0]  src_a;
        logic [IDX_W-1:0]  dst;
        logic [OPC_W-1:0]  op;
    } instr_t;

    typedef struct packed {
        logic                zero;
        logic [DATA_W-1:0]   wval;
        logic [IDX_W-1:0]    widx;
        logic                wrote;
        logic                taken;
        logic                halted;
        logic [PC_OUT_W-1:0] pc;
    } result_t;

    typedef struct packed {
        instr_t  ins;
        logic    typed;
        result_t want;
    } row_t;

    typedef enum int {
        STOP_BY_OPCODE,
        STOP_BY_JUMP,
        STOP_BY_LENGTH,
        STOP_AT_TOP
    } stop_kind_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [PLEN_W-1:0]    cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int          arch_pc;
    bit          arch_halted;
    bit          arch_zero;
    logic [31:0] arch_regs [DEF_NUM_REGS];
    logic [31:0] arch_mem [DEF_MEM_WORDS];
    int          prog_len;

    result_t pending_results [$];
    row_t    directed_rows [$];

    int  errors       = 0;
    int  items_sent   = 0;
    int  results_seen = 0;
    int  cfg_writes   = 0;
    int  cycles       = 0;
    int  stall_left   = 0;
    bit  quiet        = 1'b0;
    bit  hold_done    = 1'b0;
    stop_kind_t stop_kind;

    toy_cpu_execute_unit_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results pending.", cycles,
                     pending_results.size());
            $display("toy_cpu_execute_unit_top verification failed");
            $finish;
        end
    end

    function automatic result_t execute_instr(input instr_t ins);
        result_t         r;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] wval;
        bit              wrote;
        bit              taken;
        r     = '0;
        wval  = '0;
        wrote = 1'b0;
        taken = 1'b0;
        a     = arch_regs[ins.src_a];
        b     = arch_regs[ins.src_b];
        if (!arch_halted && arch_pc >= prog_len) begin
            arch_halted = 1'b1;
        end
        if (!arch_halted) begin
            if (arch_pc + 1 >= DEF_PROG_DEPTH) begin
                arch_pc     = TOP_PC;
                arch_halted = 1'b1;
            end else begin
                arch_pc = arch_pc + 1;
            end
            case (ins.op)
                OP_MOV: begin
                    wrote = 1'b1;
                    wval  = ins.imm;
                end
                OP_ADD: begin
                    wrote = 1'b1;
                    wval  = a + b;
                end
                OP_ADDI: begin
                    wrote = 1'b1;
                    wval  = a + ins.imm;
                end
                OP_SUB: begin
                    wrote = 1'b1;
                    wval  = a - b;
                end
                OP_AND: begin
                    wrote = 1'b1;
                    wval  = a & b;
                end
                OP_OR: begin
                    wrote = 1'b1;
                    wval  = a | b;
                end
                OP_CMP:   arch_zero = (a == b);
                OP_LOAD: begin
                    wrote = 1'b1;
                    wval  = arch_mem[ins.imm % DEF_MEM_WORDS];
                end
                OP_STORE: arch_mem[ins.imm % DEF_MEM_WORDS] = a;
                OP_JMP:   taken = 1'b1;
                OP_JZ:    taken = arch_zero;
                OP_JNZ:   taken = !arch_zero;
                OP_HALT:  arch_halted = 1'b1;
                default: ;
            endcase
            if (taken) begin
                if (ins.imm >= DEF_PROG_DEPTH) begin
                    arch_pc     = TOP_PC;
                    arch_halted = 1'b1;
                end else begin
                    arch_pc = ins.imm;
                end
            end
            if (wrote) begin
                arch_regs[ins.dst] = wval;
            end
        end
        r.pc     = arch_pc[PC_OUT_W-1:0];
        r.halted = arch_halted;
        r.taken  = taken;
        r.wrote  = wrote;
        r.widx   = wrote ? ins.dst : '0;
        r.wval   = wval;
        r.zero   = arch_zero;
        return r;
    endfunction

    function automatic instr_t mk_instr(input logic [OPC_W-1:0] op, input int dst,
                                        input int src_a, input int src_b,
                                        input logic [DATA_W-1:0] imm);
        instr_t ins;
        ins.op    = op;
        ins.dst   = dst[IDX_W-1:0];
        ins.src_a = src_a[IDX_W-1:0];
        ins.src_b = src_b[IDX_W-1:0];
        ins.imm   = imm;
        return ins;
    endfunction

    function automatic result_t mk_result(input int pc, input bit halted, input bit taken,
                                          input bit wrote, input int idx,
                                          input logic [DATA_W-1:0] val, input bit zero);
        result_t r;
        r.pc     = pc[PC_OUT_W-1:0];
        r.halted = halted;
        r.taken  = taken;
        r.wrote  = wrote;
        r.widx   = idx[IDX_W-1:0];
        r.wval   = val;
        r.zero   = zero;
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] rand_imm();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 3))
            0:       v = $urandom;
            1:       v = $urandom_range(0, 255);
            2:       v = 32'hFFFF_FFFF - $urandom_range(0, 255);
            default: begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h0000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = 32'h8000_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
        endcase
        return v;
    endfunction

    // Half of the addresses crowd into a few words so that stores and loads meet.
    function automatic logic [DATA_W-1:0] rand_addr();
        logic [DATA_W-1:0] v;
        v = $urandom;
        if ($urandom_range(0, 1) == 0) begin
            v[7:0] = 8'($urandom_range(0, 15));
        end
        return v;
    endfunction

    // Valid PCs run from 0 to one below this bound; at the top address any
    // instruction would saturate the PC and halt the machine.
    function automatic int pc_ceiling();
        return (prog_len < TOP_PC) ? prog_len : TOP_PC;
    endfunction

    function automatic instr_t pick_instr();
        instr_t ins;
        int     roll;
        int     bound;
        bound     = pc_ceiling();
        roll      = $urandom_range(0, 99);
        ins.dst   = IDX_W'($urandom_range(0, 15));
        ins.src_a = IDX_W'($urandom_range(0, 15));
        ins.src_b = IDX_W'($urandom_range(0, 15));
        ins.imm   = rand_imm();
        if (arch_pc + 1 >= bound)  ins.op = OP_JMP;
        else if (roll < 14)        ins.op = OP_MOV;
        else if (roll < 24)        ins.op = OP_ADD;
        else if (roll < 30)        ins.op = OP_ADDI;
        else if (roll < 36)        ins.op = OP_SUB;
        else if (roll < 41)        ins.op = OP_AND;
        else if (roll < 46)        ins.op = OP_OR;
        else if (roll < 58)        ins.op = OP_CMP;
        else if (roll < 68)        ins.op = OP_LOAD;
        else if (roll < 78)        ins.op = OP_STORE;
        else if (roll < 83)        ins.op = OP_JMP;
        else if (roll < 90)        ins.op = OP_JZ;
        else if (roll < 96)        ins.op = OP_JNZ;
        else if (roll < 98)        ins.op = OP_NOP;
        else                       ins.op = roll[0] ? OP_SPARE_HI : OP_SPARE_LO;
        if (ins.op == OP_CMP && $urandom_range(0, 2) == 0) begin
            ins.src_b = ins.src_a;
        end
        if (ins.op == OP_LOAD || ins.op == OP_STORE) begin
            ins.imm = rand_addr();
        end
        if (ins.op == OP_JMP || ins.op == OP_JZ || ins.op == OP_JNZ) begin
            ins.imm = $urandom_range(0, bound - 1);
        end
        return ins;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("Mismatch on result %0d: %s is %h, expected %h", results_seen, what,
                 got, want);
        errors++;
    endtask

    task automatic issue(input instr_t ins, input bit typed, input result_t want);
        result_t predicted;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ins;
        do @(posedge aclk); while (!s_tready);
        predicted = execute_instr(ins);
        pending_results.insert(pending_results.size(), typed ? want : predicted);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
    endtask

    task automatic write_prog_len(input int value);
        cfg_valid <= 1'b1;
        cfg_data  <= value[PLEN_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        prog_len = value;
        cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic add_row(input instr_t ins, input bit typed, input result_t want);
        row_t r;
        r.ins   = ins;
        r.typed = typed;
        r.want  = want;
        directed_rows.insert(directed_rows.size(), r);
    endtask

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!hold_done && results_seen >= 400) begin
            m_tready   <= 1'b0;
            hold_done  <= 1'b1;
            stall_left <= HOLD_CYCLES - 1;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 9);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_results
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[$bits(result_t)-1:0];
            results_seen++;
            if (m_tdata[M_TDATA_W-1:$bits(result_t)] != '0) begin
                report_mismatch("padding", 32'(m_tdata[M_TDATA_W-1:$bits(result_t)]), 0);
            end
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, next_pc", 32'(got.pc), 0);
            end else begin
                want = pending_results.pop_front();
                if (got.pc != want.pc)         report_mismatch("next_pc", 32'(got.pc),
                                                               32'(want.pc));
                if (got.halted != want.halted) report_mismatch("is_halted", 32'(got.halted),
                                                               32'(want.halted));
                if (got.taken != want.taken)   report_mismatch("transfer_taken",
                                                               32'(got.taken),
                                                               32'(want.taken));
                if (got.wrote != want.wrote)   report_mismatch("reg_written", 32'(got.wrote),
                                                               32'(want.wrote));
                if (got.widx != want.widx)     report_mismatch("written_index",
                                                               32'(got.widx),
                                                               32'(want.widx));
                if (got.wval != want.wval)     report_mismatch("written_value", got.wval,
                                                               want.wval);
                if (got.zero != want.zero)     report_mismatch("zero_out", 32'(got.zero),
                                                               32'(want.zero));
            end
        end
    end

    initial begin : stimulus
        int      phase_len [5];
        int      phase_count [5];
        instr_t  ins;
        result_t none;
        none        = '0;
        arch_pc     = 0;
        arch_halted = 1'b0;
        arch_zero   = 1'b0;
        prog_len    = 0;
        for (int i = 0; i < DEF_NUM_REGS; i++) arch_regs[i] = '0;
        for (int i = 0; i < DEF_MEM_WORDS; i++) arch_mem[i] = '0;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_prog_len(0);
        write_prog_len(DEF_PROG_DEPTH);

        add_row(mk_instr(OP_MOV, 0, 0, 0, 32'h7FFF_FFFF), 1'b1,
                mk_result(1, 0, 0, 1, 0, 32'h7FFF_FFFF, 0));
        add_row(mk_instr(OP_MOV, 15, 0, 0, 32'h8000_0000), 1'b1,
                mk_result(2, 0, 0, 1, 15, 32'h8000_0000, 0));
        add_row(mk_instr(OP_MOV, 1, 0, 0, 32'hFFFF_FFFF), 1'b1,
                mk_result(3, 0, 0, 1, 1, 32'hFFFF_FFFF, 0));
        add_row(mk_instr(OP_ADD, 2, 0, 15, 0), 1'b0, none);
        add_row(mk_instr(OP_ADD, 3, 1, 1, 0), 1'b0, none);
        add_row(mk_instr(OP_ADDI, 4, 0, 0, 32'h0000_0001), 1'b0, none);
        add_row(mk_instr(OP_SUB, 5, 15, 0, 0), 1'b0, none);
        add_row(mk_instr(OP_AND, 6, 1, 15, 0), 1'b0, none);
        add_row(mk_instr(OP_OR, 7, 0, 15, 0), 1'b0, none);
        add_row(mk_instr(OP_CMP, 0, 1, 2, 0), 1'b0, none);
        add_row(mk_instr(OP_JZ, 0, 0, 0, 100), 1'b0, none);
        add_row(mk_instr(OP_JNZ, 0, 0, 0, 5), 1'b0, none);
        add_row(mk_instr(OP_CMP, 0, 0, 15, 0), 1'b0, none);
        add_row(mk_instr(OP_JNZ, 0, 0, 0, TOP_PC - 2), 1'b0, none);
        add_row(mk_instr(OP_JZ, 0, 0, 0, 7), 1'b0, none);
        add_row(mk_instr(OP_JMP, 0, 0, 0, 0), 1'b1, mk_result(0, 0, 1, 0, 0, 0, 0));
        add_row(mk_instr(OP_STORE, 0, 0, 0, 32'hFFFF_FFFF), 1'b0, none);
        add_row(mk_instr(OP_LOAD, 8, 0, 0, 32'h0000_00FF), 1'b0, none);
        add_row(mk_instr(OP_LOAD, 9, 0, 0, 32'h1234_5680), 1'b0, none);
        add_row(mk_instr(OP_STORE, 0, 15, 0, 32'h8000_0000), 1'b0, none);
        add_row(mk_instr(OP_LOAD, 10, 0, 0, 32'h0000_0100), 1'b0, none);
        add_row(mk_instr(OP_ADD, 11, 10, 8, 0), 1'b0, none);
        add_row(mk_instr(OP_NOP, 15, 15, 15, 32'hFFFF_FFFF), 1'b0, none);
        add_row(mk_instr(OP_SPARE_LO, 12, 3, 4, 32'h0000_0001), 1'b0, none);
        add_row(mk_instr(OP_SPARE_HI, 13, 5, 6, 32'hFFFF_FFFF), 1'b0, none);

        foreach (directed_rows[i]) begin
            issue(directed_rows[i].ins, directed_rows[i].typed, directed_rows[i].want);
        end

        phase_len[0] = DEF_PROG_DEPTH;
        phase_len[1] = 2;
        phase_len[2] = $urandom_range(3, DEF_PROG_DEPTH);
        phase_len[3] = 1;
        phase_len[4] = DEF_PROG_DEPTH;
        phase_count  = '{450, 120, 450, 40, 700};

        // Each phase starts from PC 0 so that a shorter program stays runnable.
        for (int p = 0; p < 5; p++) begin
            issue(mk_instr(OP_JMP, 0, 0, 0, 0), 1'b0, none);
            quiesce();
            write_prog_len(phase_len[p]);
            quiet = (p == 4);
            repeat (phase_count[p]) issue(pick_instr(), 1'b0, none);
        end

        stop_kind = stop_kind_t'($urandom_range(0, 3));
        case (stop_kind)
            STOP_BY_OPCODE: begin
                issue(mk_instr(OP_HALT, $urandom_range(0, 15), $urandom_range(0, 15),
                               $urandom_range(0, 15), rand_imm()), 1'b0, none);
            end
            STOP_BY_JUMP: begin
                ins = mk_instr(OP_JMP, $urandom_range(0, 15), $urandom_range(0, 15),
                               $urandom_range(0, 15), 0);
                if ($urandom_range(0, 1) == 0) begin
                    ins.op = arch_zero ? OP_JZ : OP_JNZ;
                end
                if ($urandom_range(0, 1) == 0) begin
                    ins.imm = $urandom | 32'h8000_0000;
                end else begin
                    ins.imm = $urandom_range(32'h7FFF_FFFF, DEF_PROG_DEPTH);
                end
                issue(ins, 1'b0, none);
            end
            STOP_BY_LENGTH: begin
                quiesce();
                write_prog_len($urandom_range(0, arch_pc));
                issue(pick_instr(), 1'b0, none);
            end
            default: begin
                issue(mk_instr(OP_JMP, 0, 0, 0, TOP_PC), 1'b0, none);
                issue(mk_instr(OPC_W'($urandom_range(0, 12)), $urandom_range(0, 15),
                               $urandom_range(0, 15), $urandom_range(0, 15), rand_imm()),
                      1'b0, none);
            end
        endcase

        repeat (8) begin
            issue(mk_instr(OPC_W'($urandom_range(0, 15)), $urandom_range(0, 15),
                           $urandom_range(0, 15), $urandom_range(0, 15), $urandom),
                  1'b0, none);
        end

        quiesce();
        repeat (10) @(negedge aclk);

        $display("Ran %0d instructions with %0d results and %0d program_length writes,",
                 items_sent, results_seen, cfg_writes);
        $display("including a long output stall; the machine stopped by %s.",
                 stop_kind.name());
        if (errors == 0) begin
            $display("toy_cpu_execute_unit_top verification clean");
        end else begin
            $display("%0d mismatches found.", errors);
            $display("toy_cpu_execute_unit_top verification failed");
        end
        $finish;
    end

endmodule
